// ----- hdl/qdic_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdic_pkg
// Shared types, register map and step table for the quadrature decoder with
// index capture.
// ----------------------------------------------------------------------------
package qdic_pkg;

  localparam int CountW  = 32;
  localparam int HoldW   = 16;
  localparam int SelW    = 3;
  localparam int EnW     = 8;
  localparam int PDataW  = 32;
  localparam int PAddrW  = 4;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    CFG_JOINT_SELECT     = 2'd0,
    CFG_INDEX_CAPTURE_ON = 2'd1,
    CFG_INDEX_HOLD_TICKS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SelW-1:0]  joint_select;
    logic             index_capture_on;
    logic [HoldW-1:0] index_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic signed [CountW-1:0] reported_count;
    logic                     hold_active;
  } res_t;

  // x4 step from {new_b, new_a, old_b, old_a}
  function automatic logic signed [2:0] step_lookup(input logic [3:0] code);
    logic signed [2:0] d;
    case (code)
      4'd0:    d = 3'sd0;
      4'd1:    d = 3'sd1;
      4'd2:    d = -3'sd1;
      4'd3:    d = 3'sd2;
      4'd4:    d = -3'sd1;
      4'd5:    d = 3'sd0;
      4'd6:    d = -3'sd2;
      4'd7:    d = 3'sd1;
      4'd8:    d = 3'sd1;
      4'd9:    d = -3'sd2;
      4'd10:   d = 3'sd0;
      4'd11:   d = -3'sd1;
      4'd12:   d = 3'sd2;
      4'd13:   d = -3'sd1;
      4'd14:   d = 3'sd1;
      default: d = 3'sd0;
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/qdic_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdic_cfg_regs
// APB-style register file for select, capture enable and hold length.
// ----------------------------------------------------------------------------
module qdic_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qdic_pkg::PAddrW-1:0] paddr,
  input  logic [qdic_pkg::PDataW-1:0] pwdata,
  output logic [qdic_pkg::PDataW-1:0] prdata,
  output logic                        pready,
  output qdic_pkg::cfg_t              cfg
);

  qdic_pkg::cfg_t   cfg_r;
  qdic_pkg::cfg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = qdic_pkg::cfg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        qdic_pkg::CFG_JOINT_SELECT:     cfg_r.joint_select     <= pwdata[qdic_pkg::SelW-1:0];
        qdic_pkg::CFG_INDEX_CAPTURE_ON: cfg_r.index_capture_on <= pwdata[0];
        qdic_pkg::CFG_INDEX_HOLD_TICKS: cfg_r.index_hold_ticks <= pwdata[qdic_pkg::HoldW-1:0];
        default: ;  // unmapped: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      qdic_pkg::CFG_JOINT_SELECT:
        prdata = {{(qdic_pkg::PDataW-qdic_pkg::SelW){1'b0}}, cfg_r.joint_select};
      qdic_pkg::CFG_INDEX_CAPTURE_ON:
        prdata = {{(qdic_pkg::PDataW-1){1'b0}}, cfg_r.index_capture_on};
      qdic_pkg::CFG_INDEX_HOLD_TICKS:
        prdata = {{(qdic_pkg::PDataW-qdic_pkg::HoldW){1'b0}}, cfg_r.index_hold_ticks};
      default:
        prdata = '0;
    endcase
  end

endmodule

// ----- hdl/qdic_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdic_core
// Decoder state and per-sample update: x4 step, enable clear, index latch
// and hold countdown. Produces one result per accepted sample.
// ----------------------------------------------------------------------------
module qdic_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     chan_a,
  input  logic                     chan_b,
  input  logic                     index_level,
  input  logic [qdic_pkg::EnW-1:0] enable_bits,
  input  qdic_pkg::cfg_t           cfg,
  output qdic_pkg::res_t           res
);

  logic [1:0]                   prev_ab_r,  prev_ab_nxt;
  logic [qdic_pkg::CountW-1:0]  position_r, position_nxt;
  logic [qdic_pkg::CountW-1:0]  shown_r,    shown_nxt;
  logic [qdic_pkg::HoldW-1:0]   hold_left_r, hold_left_nxt;

  logic                         sel;
  logic signed [2:0]            step;
  logic [qdic_pkg::CountW-1:0]  pos_stepped;
  logic                         held;

  assign sel         = enable_bits[cfg.joint_select];
  assign step        = qdic_pkg::step_lookup({chan_b, chan_a, prev_ab_r});
  assign pos_stepped = position_r + {{(qdic_pkg::CountW-3){step[2]}}, step};

  always_comb begin
    prev_ab_nxt   = prev_ab_r;
    position_nxt  = position_r;
    shown_nxt     = shown_r;
    hold_left_nxt = hold_left_r;
    held          = 1'b0;
    if (!sel) begin
      // disabled: zero count and output, keep edge history and hold
      position_nxt = '0;
      shown_nxt    = '0;
    end else begin
      prev_ab_nxt  = {chan_b, chan_a};
      position_nxt = pos_stepped;
      if (cfg.index_capture_on) begin
        if (index_level && hold_left_r == '0) begin
          shown_nxt     = pos_stepped;
          hold_left_nxt = cfg.index_hold_ticks;
        end else if (hold_left_r != '0) begin
          hold_left_nxt = hold_left_r - 1'b1;
        end else begin
          shown_nxt = pos_stepped;
        end
        held = (hold_left_nxt != '0);
      end else begin
        shown_nxt = pos_stepped;
      end
    end
  end

  assign res.reported_count = signed'(shown_nxt);
  assign res.hold_active    = held;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ab_r   <= '0;
      position_r  <= '0;
      shown_r     <= '0;
      hold_left_r <= '0;
    end else if (accept) begin
      prev_ab_r   <= prev_ab_nxt;
      position_r  <= position_nxt;
      shown_r     <= shown_nxt;
      hold_left_r <= hold_left_nxt;
    end
  end

endmodule

// ----- hdl/qdic_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdic_out_buf
// Result register with one skid entry, so a request is taken while the
// previous result waits on the receiver.
// ----------------------------------------------------------------------------
module qdic_out_buf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qdic_pkg::res_t push_res,
  output logic           can_push,
  output logic           out_valid,
  input  logic           out_ready,
  output qdic_pkg::res_t out_res
);

  logic           main_valid_r, main_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  qdic_pkg::res_t main_r, main_nxt;
  qdic_pkg::res_t skid_r, skid_nxt;
  logic           pop;

  assign pop       = main_valid_r & out_ready;
  assign can_push  = ~skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // advance skid into the output slot once it drains
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- hdl/quadrature_decoder_index_capture.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_decoder_index_capture
// x4 quadrature decoder with joint enable and index latch/hold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one request per sample tick carrying
//   the A, B and index levels and the joint-enable byte.
//   Output channel (out_valid/out_ready): one result per request, the count
//   presented this tick and the hold flag.
//   Registers (APB): 0x0 joint_select, 0x4 index_capture_on,
//   0x8 index_hold_ticks. Write only while idle.
// Timing:
//   A request is decoded in the cycle it is taken; its result goes to the
//   result register, or to the skid entry while the receiver stalls. One
//   request per cycle is sustained while the skid entry is free, set by
//   the state update (step add, hold countdown) feeding the result register.
// Reset (rst_n, synchronous): registers, count, output value, edge history
//   and hold counter go to zero; no results pending.
// Stall: a result register plus one skid entry absorb a stalled receiver;
//   in_ready drops only while both are occupied.
// ----------------------------------------------------------------------------
module quadrature_decoder_index_capture (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_chan_a,
  input  logic                               in_chan_b,
  input  logic                               in_index_level,
  input  logic [qdic_pkg::EnW-1:0]           in_enable_bits,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [qdic_pkg::CountW-1:0] out_reported_count,
  output logic                               out_hold_active,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qdic_pkg::PAddrW-1:0]        paddr,
  input  logic [qdic_pkg::PDataW-1:0]        pwdata,
  output logic [qdic_pkg::PDataW-1:0]        prdata,
  output logic                               pready
);

  qdic_pkg::cfg_t cfg;
  qdic_pkg::res_t core_res;
  qdic_pkg::res_t buf_res;
  logic           accept;

  assign accept = in_valid & in_ready;

  qdic_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qdic_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .chan_a      (in_chan_a),
    .chan_b      (in_chan_b),
    .index_level (in_index_level),
    .enable_bits (in_enable_bits),
    .cfg         (cfg),
    .res         (core_res)
  );

  qdic_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_res  (core_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (buf_res)
  );

  assign out_reported_count = buf_res.reported_count;
  assign out_hold_active    = buf_res.hold_active;

endmodule

// ----- bench/quadrature_decoder_index_capture_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_decoder_index_capture_checker
// Watches the sample, result and register ports of the decoder. It tracks the
// position count, the shown value and the index hold on its own, and compares
// every result the block hands out against the oldest predicted one.
// ----------------------------------------------------------------------------
module quadrature_decoder_index_capture_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               in_chan_a,
  input  logic                               in_chan_b,
  input  logic                               in_index_level,
  input  logic [qdic_pkg::EnW-1:0]           in_enable_bits,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [qdic_pkg::CountW-1:0] out_reported_count,
  input  logic                               out_hold_active,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [qdic_pkg::PAddrW-1:0]        paddr,
  input  logic [qdic_pkg::PDataW-1:0]        pwdata,
  output int                                 mismatches,
  output int                                 outstanding
);

  import qdic_pkg::*;

  // register copies
  logic [SelW-1:0]   sel_bit;
  logic              capture_on;
  logic [HoldW-1:0]  hold_len;

  // decoder state
  logic [1:0]        last_ab;   // A in bit 0, B in bit 1
  logic [CountW-1:0] position;
  logic [CountW-1:0] shown;
  logic [HoldW-1:0]  hold_left;

  res_t expected_reports[$];

  function automatic res_t track_position(input logic a, input logic b, input logic idx,
                                          input logic [EnW-1:0] en);
    res_t              r;
    logic [1:0]        ph_old;
    logic [1:0]        ph_new;
    logic [1:0]        turn;
    logic [CountW-1:0] delta;
    r = '0;
    if (!en[sel_bit]) begin
      // disabled: clear count and shown value, keep edge history and hold
      position = '0;
      shown = '0;
      return r;
    end
    // map A/B onto a quarter-turn phase; B leading A counts up
    ph_old = {last_ab[0], last_ab[0] ^ last_ab[1]};
    ph_new = {a, a ^ b};
    turn = ph_new - ph_old;
    case (turn)
      2'd1:    delta = 32'd1;
      2'd3:    delta = 32'hFFFF_FFFF;
      // both channels moved: sign follows the parity of the old phase
      2'd2:    delta = ph_old[0] ? 32'hFFFF_FFFE : 32'd2;
      default: delta = '0;
    endcase
    position = position + delta;
    last_ab = {b, a};
    if (capture_on) begin
      if (idx && hold_left == '0) begin
        shown = position;
        hold_left = hold_len;
      end else if (hold_left != '0) begin
        hold_left = hold_left - 1'b1;
      end else begin
        shown = position;
      end
      r.hold_active = (hold_left != '0);
    end else begin
      shown = position;
    end
    r.reported_count = shown;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    int   bad;
    bad = 0;
    if (!rst_n) begin
      sel_bit = '0;
      capture_on = 1'b0;
      hold_len = '0;
      last_ab = '0;
      position = '0;
      shown = '0;
      hold_left = '0;
      expected_reports.delete();
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          CFG_JOINT_SELECT:     sel_bit = pwdata[SelW-1:0];
          CFG_INDEX_CAPTURE_ON: capture_on = pwdata[0];
          CFG_INDEX_HOLD_TICKS: hold_len = pwdata[HoldW-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result: reported_count %0d hold_active %0b",
                 out_reported_count, out_hold_active);
          bad++;
        end else begin
          want = expected_reports.pop_front();
          if (out_reported_count !== want.reported_count) begin
            $error("reported_count: expected %0d, got %0d",
                   want.reported_count, out_reported_count);
            bad++;
          end
          if (out_hold_active !== want.hold_active) begin
            $error("hold_active: expected %0b, got %0b", want.hold_active, out_hold_active);
            bad++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_reports.push_back(track_position(in_chan_a, in_chan_b, in_index_level,
                                                  in_enable_bits));
      end
      outstanding <= expected_reports.size();
      mismatches <= mismatches + bad;
    end
  end

endmodule

// ----- bench/quadrature_decoder_index_capture_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_decoder_index_capture_tb
// Drives sample requests and register writes into the decoder: a directed
// opening, then phases of random encoder walks under different register
// settings and handshake pressure. The checker does the prediction.
// ----------------------------------------------------------------------------
module quadrature_decoder_index_capture_tb;

  import qdic_pkg::*;

  localparam int         CYCLE_LIMIT    = 200000;
  localparam int         HOLDOFF_CYCLES = 300;
  localparam int         PHASE_ITEMS    = 240;
  localparam int         PHASE_COUNT    = 8;
  localparam logic [1:0] UNUSED_REG     = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_chan_a = 1'b0;
  logic                  in_chan_b = 1'b0;
  logic                  in_index_level = 1'b0;
  logic [EnW-1:0]        in_enable_bits = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [CountW-1:0] out_reported_count;
  logic                  out_hold_active;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PAddrW-1:0]     paddr = '0;
  logic [PDataW-1:0]     pwdata = '0;
  logic [PDataW-1:0]     prdata;
  logic                  pready;

  int                    fail_count;
  int                    pending;
  int                    cycle_cnt = 0;
  int                    gap_pct = 0;
  int                    stall_pct = 0;
  logic                  holdoff_req = 1'b0;
  int                    holdoff_cnt = 0;
  logic [SelW-1:0]       cur_sel = '0;
  logic                  walk_a = 1'b0;
  logic                  walk_b = 1'b0;
  int                    index_run = 0;

  quadrature_decoder_index_capture i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_chan_a          (in_chan_a),
    .in_chan_b          (in_chan_b),
    .in_index_level     (in_index_level),
    .in_enable_bits     (in_enable_bits),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reported_count (out_reported_count),
    .out_hold_active    (out_hold_active),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  quadrature_decoder_index_capture_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_chan_a          (in_chan_a),
    .in_chan_b          (in_chan_b),
    .in_index_level     (in_index_level),
    .in_enable_bits     (in_enable_bits),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reported_count (out_reported_count),
    .out_hold_active    (out_hold_active),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .mismatches         (fail_count),
    .outstanding        (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (holdoff_req && holdoff_cnt < HOLDOFF_CYCLES) begin
      out_ready <= 1'b0;
      holdoff_cnt <= holdoff_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // offer one request and hold it until taken; valid stays up afterwards
  task automatic offer_sample(input logic a, input logic b, input logic idx,
                              input logic [EnW-1:0] en);
    in_valid <= 1'b1;
    in_chan_a <= a;
    in_chan_b <= b;
    in_index_level <= idx;
    in_enable_bits <= en;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [PDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // junk in the unused upper bits must not matter
  task automatic set_config(input logic [SelW-1:0] sel, input logic cap,
                            input logic [HoldW-1:0] hold);
    logic [PDataW-1:0] data;
    data = $urandom();
    data[SelW-1:0] = sel;
    reg_write(CFG_JOINT_SELECT, data);
    data = $urandom();
    data[0] = cap;
    reg_write(CFG_INDEX_CAPTURE_ON, data);
    data = $urandom();
    data[HoldW-1:0] = hold;
    reg_write(CFG_INDEX_HOLD_TICKS, data);
    cur_sel = sel;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic random_sample();
    int             r;
    logic           idx;
    logic [EnW-1:0] en;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      if ($urandom_range(0, 1)) walk_a = ~walk_a;
      else walk_b = ~walk_b;
    end else if (r >= 80 && r < 88) begin
      walk_a = ~walk_a;
      walk_b = ~walk_b;
    end else if (r >= 88) begin
      walk_a = 1'($urandom_range(0, 1));
      walk_b = 1'($urandom_range(0, 1));
    end
    if (index_run == 0 && $urandom_range(0, 99) < 7) index_run = $urandom_range(1, 4);
    idx = (index_run != 0);
    if (index_run != 0) index_run--;
    en = EnW'($urandom_range(0, 255));
    en[cur_sel] = ($urandom_range(0, 99) >= 10);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    offer_sample(walk_a, walk_b, idx, en);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: bit 0 selects, capture off
    offer_sample(1'b0, 1'b0, 1'b0, 8'h00);
    offer_sample(1'b1, 1'b0, 1'b0, 8'h01);
    offer_sample(1'b1, 1'b1, 1'b0, 8'hFF);
    offer_sample(1'b0, 1'b1, 1'b1, 8'h01);
    offer_sample(1'b0, 1'b0, 1'b0, 8'h01);
    offer_sample(1'b0, 1'b1, 1'b0, 8'h01);
    offer_sample(1'b1, 1'b1, 1'b0, 8'h01);
    offer_sample(1'b0, 1'b0, 1'b0, 8'h01);
    offer_sample(1'b1, 1'b1, 1'b0, 8'h01);
    offer_sample(1'b0, 1'b0, 1'b0, 8'hFE);
    drain();

    // write past the register list, then arm capture on the top enable bit
    reg_write(UNUSED_REG, $urandom());
    set_config(3'd7, 1'b1, 16'd3);
    offer_sample(1'b1, 1'b0, 1'b1, 8'h80);
    offer_sample(1'b1, 1'b1, 1'b1, 8'h80);
    offer_sample(1'b0, 1'b1, 1'b0, 8'h80);
    offer_sample(1'b0, 1'b0, 1'b0, 8'h80);
    offer_sample(1'b0, 1'b1, 1'b1, 8'hFF);
    // disable in the middle of a hold, then resume it
    offer_sample(1'b0, 1'b0, 1'b0, 8'h7F);
    offer_sample(1'b1, 1'b0, 1'b0, 8'h80);
    offer_sample(1'b1, 1'b1, 1'b0, 8'h80);
    offer_sample(1'b0, 1'b1, 1'b0, 8'h80);
    drain();

    // zero hold length: every index tick latches
    set_config(3'd7, 1'b1, 16'd0);
    offer_sample(1'b0, 1'b0, 1'b1, 8'h80);
    offer_sample(1'b1, 1'b0, 1'b1, 8'h80);
    offer_sample(1'b1, 1'b1, 1'b1, 8'h80);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain();
      case (ph)
        0: begin
          set_config(3'd0, 1'b0, 16'd0);
          gap_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          set_config(3'd7, 1'b1, 16'd5);
          gap_pct = 51;
          stall_pct <= 0;
        end
        2: begin
          set_config(3'd3, 1'b1, 16'd0);
          gap_pct = 0;
          stall_pct <= 51;
        end
        3: begin
          set_config(3'd1, 1'b1, 16'($urandom_range(1, 40)));
          gap_pct = 19;
          stall_pct <= 19;
        end
        4: begin
          // back-to-back requests against a long stall on the result side
          set_config(3'd6, 1'b0, 16'd100);
          gap_pct = 0;
          stall_pct <= 0;
          holdoff_req <= 1'b1;
        end
        5: begin
          set_config(3'd2, 1'b1, 16'd1);
          gap_pct = 51;
          stall_pct <= 0;
        end
        6: begin
          set_config(3'd4, 1'b1, 16'd12);
          gap_pct = 0;
          stall_pct <= 51;
        end
        default: begin
          set_config(3'd5, 1'b1, 16'hFFFF);
          gap_pct = 19;
          stall_pct <= 19;
        end
      endcase
      repeat (PHASE_ITEMS) random_sample();
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/qdic_pkg.sv
hdl/qdic_cfg_regs.sv
hdl/qdic_core.sv
hdl/qdic_out_buf.sv
hdl/quadrature_decoder_index_capture.sv
bench/quadrature_decoder_index_capture_checker.sv
bench/quadrature_decoder_index_capture_tb.sv
